// ===== hdl/mcd_pkg.sv =====
// Shared types and constants of the marker crossing detector.
package mcd_pkg;

	localparam int POS_W  = 64;
	localparam int SLOT_W = 4;

	// Operation codes carried by an input transaction.
	typedef enum logic [1:0] {
		OP_POLL   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_FORGET = 2'd2,
		OP_SET    = 2'd3
	} op_t;

	// Sequencer states of the crossing scan.
	typedef enum logic [1:0] {
		ST_IDLE    = 2'd0,
		ST_SCAN    = 2'd1,
		ST_FINISH  = 2'd2,
		ST_RESOLVE = 2'd3
	} state_t;

	// Context that the candidate comparator needs for one scan pass.
	typedef struct packed {
		logic [POS_W-1:0] last_pos;
		logic [POS_W-1:0] cur_pos;
		logic [POS_W-1:0] prev_pos;
		logic [POS_W-1:0] best_pos;
		logic             have_prev;
		logic             best_found;
	} scan_ctx_t;

endpackage

// ===== hdl/mcd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mcd_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/mcd_cand.sv =====
// Candidate comparator: decides whether one marker beats the current best in a scan pass.
module mcd_cand #(
	parameter int AW = 4
) (
	input  mcd_pkg::scan_ctx_t            ctx,
	input  logic [mcd_pkg::POS_W-1:0]     marker_pos,
	input  logic [AW-1:0]                 marker_slot,
	input  logic [AW-1:0]                 prev_slot,
	input  logic                          marker_present,
	output logic                          take
);

	logic after_prev;
	logic within_cur;
	logic beats_best;

	// The marker must come after the previous key, not pass the transport,
	// and sort strictly before the best found so far in this pass.
	always_comb begin
		if (ctx.have_prev) begin
			after_prev = ($signed(marker_pos) > $signed(ctx.prev_pos)) ||
				((marker_pos == ctx.prev_pos) && (marker_slot > prev_slot));
		end else begin
			after_prev = $signed(marker_pos) > $signed(ctx.last_pos);
		end
		within_cur = $signed(marker_pos) <= $signed(ctx.cur_pos);
		beats_best = !ctx.best_found || ($signed(marker_pos) < $signed(ctx.best_pos));
		take = marker_present && after_prev && within_cur && beats_best;
	end

endmodule

// ===== hdl/marker_crossing_detector.sv =====
// Top level of the marker crossing detector: command port, sequencer and slot table.
//
// Write, forget and set transactions, and polls that cannot cross anything, finish in the
// cycle they are accepted. A poll that advances the transport scans the slot table once per
// crossing plus one final pass; each pass reads one slot per cycle from the table RAM through
// a single comparator, and busy stays high until the final pass is resolved. Results come
// out on result_valid for one cycle each, at least a full scan pass apart, in ascending
// position order with ties by slot; the final one carries last. The receiver cannot stall,
// so results must be taken when shown.
module marker_crossing_detector #(
	parameter int MARKER_SLOTS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           operation,
	input  logic signed [mcd_pkg::POS_W-1:0]     position,
	input  logic                                 rolling,
	input  logic                                 discontinuity,
	input  logic [mcd_pkg::SLOT_W-1:0]           slot,
	input  logic                                 present,
	output logic                                 result_valid,
	output logic [mcd_pkg::SLOT_W-1:0]           crossed_slot,
	output logic signed [mcd_pkg::POS_W-1:0]     crossed_position,
	output logic                                 last
);

	localparam int AW = (MARKER_SLOTS > 1) ? $clog2(MARKER_SLOTS) : 1;
	localparam logic [AW-1:0] LAST_SLOT = AW'(MARKER_SLOTS - 1);

	mcd_pkg::state_t state_q, state_d;
	logic accept;
	logic poll_go;
	logic slot_in_range;
	logic scan_issue;
	logic resolve;
	logic take;

	logic [AW-1:0]               cnt_q;
	logic                        rd_v_s1;
	logic [AW-1:0]               rd_slot_s1;
	logic [mcd_pkg::POS_W-1:0]   rd_pos;
	logic [mcd_pkg::POS_W-1:0]   last_pos_q;
	logic                        known_q;
	logic [mcd_pkg::POS_W-1:0]   cur_pos_q;
	logic [mcd_pkg::POS_W-1:0]   prev_pos_q;
	logic [AW-1:0]               prev_slot_q;
	logic                        have_prev_q;
	logic [mcd_pkg::POS_W-1:0]   best_pos_q;
	logic [AW-1:0]               best_slot_q;
	logic                        best_found_q;
	logic [mcd_pkg::POS_W-1:0]   held_pos_q;
	logic [AW-1:0]               held_slot_q;
	logic                        held_v_q;
	logic                        present_q [MARKER_SLOTS];
	logic                        out_valid_q;
	logic                        out_last_q;
	logic [mcd_pkg::SLOT_W-1:0]  out_slot_q;
	logic [mcd_pkg::POS_W-1:0]   out_pos_q;
	mcd_pkg::scan_ctx_t          ctx;

	// Transaction acceptance and decode.
	assign accept = start && (state_q == mcd_pkg::ST_IDLE);
	assign slot_in_range = {28'd0, slot} < 32'(MARKER_SLOTS);
	assign poll_go = (operation == mcd_pkg::OP_POLL) && rolling && !discontinuity &&
		known_q && ($signed(last_pos_q) < position);

	// Next-state logic of the scan sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			mcd_pkg::ST_IDLE: begin
				if (accept && poll_go) begin
					state_d = mcd_pkg::ST_SCAN;
				end
			end
			mcd_pkg::ST_SCAN: begin
				if (cnt_q == LAST_SLOT) begin
					state_d = mcd_pkg::ST_FINISH;
				end
			end
			mcd_pkg::ST_FINISH: begin
				state_d = mcd_pkg::ST_RESOLVE;
			end
			mcd_pkg::ST_RESOLVE: begin
				state_d = best_found_q ? mcd_pkg::ST_SCAN : mcd_pkg::ST_IDLE;
			end
			default: begin
				state_d = mcd_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		busy       = 1'b1;
		scan_issue = 1'b0;
		resolve    = 1'b0;
		case (state_q)
			mcd_pkg::ST_IDLE: begin
				busy = 1'b0;
			end
			mcd_pkg::ST_SCAN: begin
				scan_issue = 1'b1;
			end
			mcd_pkg::ST_FINISH: begin
			end
			mcd_pkg::ST_RESOLVE: begin
				resolve = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	// Marker position table, read one slot per cycle during a scan.
	mcd_ram #(
		.WIDTH(mcd_pkg::POS_W),
		.DEPTH(MARKER_SLOTS)
	) u_table (
		.clk   (clk),
		.we    (accept && (operation == mcd_pkg::OP_WRITE) && slot_in_range),
		.waddr (AW'(slot)),
		.wdata (position),
		.raddr (cnt_q),
		.rdata (rd_pos)
	);

	// Comparator context for the current pass.
	always_comb begin
		ctx.last_pos   = last_pos_q;
		ctx.cur_pos    = cur_pos_q;
		ctx.prev_pos   = prev_pos_q;
		ctx.best_pos   = best_pos_q;
		ctx.have_prev  = have_prev_q;
		ctx.best_found = best_found_q;
	end

	mcd_cand #(
		.AW(AW)
	) u_cand (
		.ctx            (ctx),
		.marker_pos     (rd_pos),
		.marker_slot    (rd_slot_s1),
		.prev_slot      (prev_slot_q),
		.marker_present (rd_v_s1 && present_q[rd_slot_s1]),
		.take           (take)
	);

	// Control state: sequencer, transport position, present bits and strobes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= mcd_pkg::ST_IDLE;
			cnt_q        <= '0;
			rd_v_s1      <= 1'b0;
			last_pos_q   <= '0;
			known_q      <= 1'b0;
			have_prev_q  <= 1'b0;
			best_found_q <= 1'b0;
			held_v_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < MARKER_SLOTS; i++) begin
				present_q[AW'(i)] <= 1'b0;
			end
		end else begin
			state_q     <= state_d;
			rd_v_s1     <= scan_issue;
			out_valid_q <= resolve && held_v_q;
			cnt_q       <= scan_issue ? cnt_q + AW'(1) : '0;
			if (accept) begin
				case (operation)
					mcd_pkg::OP_WRITE: begin
						if (slot_in_range) begin
							present_q[AW'(slot)] <= present;
						end
					end
					mcd_pkg::OP_FORGET: begin
						known_q    <= 1'b0;
						last_pos_q <= '0;
					end
					default: begin
						if (poll_go) begin
							have_prev_q  <= 1'b0;
							best_found_q <= 1'b0;
							held_v_q     <= 1'b0;
						end else begin
							known_q    <= 1'b1;
							last_pos_q <= position;
						end
					end
				endcase
			end
			if (take) begin
				best_found_q <= 1'b1;
			end
			if (resolve) begin
				best_found_q <= 1'b0;
				if (best_found_q) begin
					have_prev_q <= 1'b1;
					held_v_q    <= 1'b1;
				end else begin
					held_v_q   <= 1'b0;
					last_pos_q <= cur_pos_q;
				end
			end
		end
	end

	// Payload registers: scan keys, held result and output fields.
	always_ff @(posedge clk) begin
		rd_slot_s1 <= cnt_q;
		if (accept && poll_go) begin
			cur_pos_q <= position;
		end
		if (take) begin
			best_pos_q  <= rd_pos;
			best_slot_q <= rd_slot_s1;
		end
		if (resolve && best_found_q) begin
			prev_pos_q  <= best_pos_q;
			prev_slot_q <= best_slot_q;
			held_pos_q  <= best_pos_q;
			held_slot_q <= best_slot_q;
		end
		if (resolve) begin
			out_pos_q  <= held_pos_q;
			out_slot_q <= mcd_pkg::SLOT_W'(held_slot_q);
			out_last_q <= !best_found_q;
		end
	end

	assign result_valid     = out_valid_q;
	assign crossed_slot     = out_slot_q;
	assign crossed_position = out_pos_q;
	assign last             = out_last_q;

	// A non-final result means another scan pass is running; the final one ends the poll.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (busy == !last))
		else $error("result strobe and busy disagree on the end of a poll");

	// Result strobes never come back to back; results of one poll are separated by at least a full scan pass.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe high in two consecutive cycles");

	// A scan never starts unless the poll was accepted while idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mcd_pkg::ST_IDLE) && !(start && poll_go) |=> (state_q == mcd_pkg::ST_IDLE))
		else $error("scan started without an accepted poll");

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench of the marker crossing detector: driver, monitor and predictor.
module tb;

	localparam int ITEM_TARGET = 360;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 100;
	localparam int SLOTS = 16;
	localparam logic signed [mcd_pkg::POS_W-1:0] POS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [mcd_pkg::POS_W-1:0] POS_MIN = 64'sh8000_0000_0000_0000;

	// One command transaction as it is put on the input ports.
	typedef struct {
		mcd_pkg::op_t                      operation;
		logic signed [mcd_pkg::POS_W-1:0]  position;
		logic                              rolling;
		logic                              discontinuity;
		logic [mcd_pkg::SLOT_W-1:0]        slot;
		logic                              present;
	} marker_cmd_t;

	// One crossing report as it appears on the result ports.
	typedef struct {
		logic [mcd_pkg::SLOT_W-1:0]        slot;
		logic signed [mcd_pkg::POS_W-1:0]  position;
		logic                              last;
	} crossing_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] operation = mcd_pkg::OP_POLL;
	logic signed [mcd_pkg::POS_W-1:0] position = '0;
	logic rolling = 1'b0;
	logic discontinuity = 1'b0;
	logic [mcd_pkg::SLOT_W-1:0] slot = '0;
	logic present = 1'b0;
	logic result_valid;
	logic [mcd_pkg::SLOT_W-1:0] crossed_slot;
	logic signed [mcd_pkg::POS_W-1:0] crossed_position;
	logic last;

	marker_cmd_t pending_cmds[$];
	crossing_t crossings_due[$];
	marker_cmd_t held_cmd;
	logic holding = 1'b0;
	int idle_left = 0;
	int calm_left = 0;
	int quiet_cycles = 0;
	int cmds_taken = 0;
	int crossing_polls = 0;
	int reports_checked = 0;
	int mismatches = 0;
	crossing_t oldest_due;

	// Predictor copy of the transport state and the slot table.
	logic signed [mcd_pkg::POS_W-1:0] head_pos = '0;
	logic head_known = 1'b0;
	logic signed [mcd_pkg::POS_W-1:0] mark_pos[SLOTS];
	logic mark_on[SLOTS];

	marker_crossing_detector #(
		.MARKER_SLOTS(SLOTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.position(position),
		.rolling(rolling),
		.discontinuity(discontinuity),
		.slot(slot),
		.present(present),
		.result_valid(result_valid),
		.crossed_slot(crossed_slot),
		.crossed_position(crossed_position),
		.last(last)
	);

	// Clock and a single reset pulse at the start of the run.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Updates the predicted state for one accepted command and queues the crossings it causes.
	task automatic forecast_crossings(input marker_cmd_t c);
		logic [mcd_pkg::SLOT_W-1:0] hits[$];
		int k;
		int j;
		logic [mcd_pkg::SLOT_W-1:0] held;
		crossing_t x;
		case (c.operation)
			mcd_pkg::OP_WRITE: begin
				mark_pos[c.slot] = c.position;
				mark_on[c.slot] = c.present;
			end
			mcd_pkg::OP_FORGET: begin
				head_known = 1'b0;
				head_pos = '0;
			end
			default: begin
				if (c.operation == mcd_pkg::OP_SET || !c.rolling || c.discontinuity ||
						!head_known || !(head_pos < c.position)) begin
					head_known = 1'b1;
					head_pos = c.position;
				end else begin
					// Gather crossed slots in slot order, then sort stably by position.
					for (k = 0; k < SLOTS; k++) begin
						if (mark_on[mcd_pkg::SLOT_W'(k)] &&
								mark_pos[mcd_pkg::SLOT_W'(k)] > head_pos &&
								mark_pos[mcd_pkg::SLOT_W'(k)] <= c.position)
							hits.insert(hits.size(), mcd_pkg::SLOT_W'(k));
					end
					for (k = 1; k < hits.size(); k++) begin
						held = hits[k];
						j = k;
						while (j > 0 && mark_pos[held] < mark_pos[hits[j-1]]) begin
							hits[j] = hits[j-1];
							j--;
						end
						hits[j] = held;
					end
					for (k = 0; k < hits.size(); k++) begin
						x.slot = hits[k];
						x.position = mark_pos[hits[k]];
						x.last = (k == hits.size() - 1);
						crossings_due.insert(crossings_due.size(), x);
					end
					if (hits.size() != 0)
						crossing_polls++;
					head_pos = c.position;
				end
			end
		endcase
	endtask

	// Appends one command to the end of the pending queue.
	task automatic queue_cmd(input marker_cmd_t c);
		pending_cmds.insert(pending_cmds.size(), c);
	endtask

	// Pause before the next command, with runs of back-to-back commands now and then.
	function automatic int draw_gap();
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			calm_left = $urandom_range(5, 30);
			return 0;
		end
		return $urandom_range(0, 13);
	endfunction

	function automatic marker_cmd_t cmd_poll(logic signed [mcd_pkg::POS_W-1:0] pos,
			logic roll, logic jump);
		marker_cmd_t c;
		c.operation = mcd_pkg::OP_POLL;
		c.position = pos;
		c.rolling = roll;
		c.discontinuity = jump;
		c.slot = mcd_pkg::SLOT_W'($urandom_range(0, 15));
		c.present = 1'($urandom_range(0, 1));
		return c;
	endfunction

	function automatic marker_cmd_t cmd_write(int idx, logic signed [mcd_pkg::POS_W-1:0] pos,
			logic on);
		marker_cmd_t c;
		c.operation = mcd_pkg::OP_WRITE;
		c.position = pos;
		c.rolling = 1'($urandom_range(0, 1));
		c.discontinuity = 1'($urandom_range(0, 1));
		c.slot = idx[mcd_pkg::SLOT_W-1:0];
		c.present = on;
		return c;
	endfunction

	// Set and forget commands; the position only matters for set.
	function automatic marker_cmd_t cmd_move(mcd_pkg::op_t op,
			logic signed [mcd_pkg::POS_W-1:0] pos);
		marker_cmd_t c;
		c.operation = op;
		c.position = pos;
		c.rolling = 1'($urandom_range(0, 1));
		c.discontinuity = 1'($urandom_range(0, 1));
		c.slot = mcd_pkg::SLOT_W'($urandom_range(0, 15));
		c.present = 1'($urandom_range(0, 1));
		return c;
	endfunction

	// Driver: holds a command on the ports until the block takes it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			holding = 1'b0;
			idle_left = 0;
		end else begin
			if (start && !busy) begin
				forecast_crossings(held_cmd);
				cmds_taken++;
				holding = 1'b0;
				idle_left = draw_gap();
			end
			if (!holding) begin
				if (idle_left > 0) begin
					idle_left--;
				end else if (pending_cmds.size() != 0) begin
					held_cmd = pending_cmds.pop_front();
					operation <= held_cmd.operation;
					position <= held_cmd.position;
					rolling <= held_cmd.rolling;
					discontinuity <= held_cmd.discontinuity;
					slot <= held_cmd.slot;
					present <= held_cmd.present;
					holding = 1'b1;
				end
			end
			start <= holding;
		end
	end

	// Monitor: every strobed result is matched against the oldest predicted crossing.
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			reports_checked++;
			if (crossings_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected crossing report: slot %0d position %0d last %0b",
						crossed_slot, crossed_position, last);
			end else begin
				oldest_due = crossings_due.pop_front();
				if (crossed_slot !== oldest_due.slot ||
						crossed_position !== oldest_due.position ||
						last !== oldest_due.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Crossing mismatch: expected slot %0d position %0d last %0b,",
							oldest_due.slot, oldest_due.position, oldest_due.last);
						$display("  got slot %0d position %0d last %0b",
							crossed_slot, crossed_position, last);
					end
				end
			end
		end
	end

	// Watchdog: too long without any transaction or result ends the run.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles, %0d crossings still due",
				WATCHDOG_LIMIT, crossings_due.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Stimulus: directed commands first, then random sequences around a moving transport.
	initial begin
		logic signed [mcd_pkg::POS_W-1:0] cursor;
		marker_cmd_t noise;
		int pick;
		int n;
		int i;
		int r;

		// The predicted slot table starts with every slot empty.
		for (i = 0; i < SLOTS; i++)
			mark_on[mcd_pkg::SLOT_W'(i)] = 1'b0;

		// Load every slot, covering the position extremes, ties and cleared slots.
		queue_cmd(cmd_write(0, POS_MIN, 1'b1));
		queue_cmd(cmd_write(1, POS_MAX, 1'b1));
		queue_cmd(cmd_write(2, 64'sd0, 1'b1));
		queue_cmd(cmd_write(3, -64'sd1, 1'b1));
		queue_cmd(cmd_write(4, 64'sd50, 1'b1));
		queue_cmd(cmd_write(5, 64'sd50, 1'b1));
		queue_cmd(cmd_write(6, 64'sd20, 1'b0));
		queue_cmd(cmd_write(7, 64'sd200, 1'b1));
		queue_cmd(cmd_write(8, 64'sd100, 1'b1));
		queue_cmd(cmd_write(9, -64'sd50, 1'b1));
		queue_cmd(cmd_write(10, 64'sd150, 1'b1));
		for (i = 11; i < 15; i++)
			queue_cmd(cmd_write(i, 64'sd5000 + i, 1'b0));
		queue_cmd(cmd_write(15, 64'sd300, 1'b1));
		// Crossing from negative to positive, with a tie resolved by slot and a hit on the end.
		queue_cmd(cmd_move(mcd_pkg::OP_SET, -64'sd100));
		queue_cmd(cmd_poll(64'sd150, 1'b1, 1'b0));
		queue_cmd(cmd_poll(64'sd300, 1'b1, 1'b0));
		// Stopped transport, a jump, and a poll with no known position.
		queue_cmd(cmd_poll(64'sd1000, 1'b0, 1'b0));
		queue_cmd(cmd_poll(64'sd2000, 1'b1, 1'b1));
		queue_cmd(cmd_move(mcd_pkg::OP_FORGET, 64'sd777));
		queue_cmd(cmd_poll(POS_MAX, 1'b1, 1'b0));
		// Sweep of the whole signed range, then a backward poll.
		queue_cmd(cmd_move(mcd_pkg::OP_SET, POS_MIN));
		queue_cmd(cmd_poll(POS_MAX, 1'b1, 1'b0));
		queue_cmd(cmd_poll(POS_MIN, 1'b1, 1'b0));

		while (pending_cmds.size() < ITEM_TARGET) begin
			if ($urandom_range(0, 9) == 0) begin
				// Noise: any operation with arbitrary field values.
				noise.operation = mcd_pkg::op_t'($urandom_range(0, 3));
				noise.position = {$urandom, $urandom};
				noise.rolling = 1'($urandom_range(0, 1));
				noise.discontinuity = 1'($urandom_range(0, 1));
				noise.slot = mcd_pkg::SLOT_W'($urandom_range(0, 15));
				noise.present = 1'($urandom_range(0, 1));
				queue_cmd(noise);
			end else begin
				// Pick a region, mostly near zero, sometimes at either end of the range.
				pick = $urandom_range(0, 19);
				if (pick < 14)
					cursor = 64'($urandom_range(0, 2000000)) - 64'sd1000000;
				else if (pick < 17)
					cursor = POS_MAX - 64'($urandom_range(0, 3000));
				else
					cursor = POS_MIN + 64'($urandom_range(0, 3000));
				if ($urandom_range(0, 4) == 0) begin
					queue_cmd(cmd_move(mcd_pkg::OP_FORGET, {$urandom, $urandom}));
					queue_cmd(cmd_poll(cursor, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1))));
				end else begin
					queue_cmd(cmd_move(mcd_pkg::OP_SET, cursor));
				end
				n = $urandom_range(1, 4);
				for (i = 0; i < n; i++)
					queue_cmd(cmd_write($urandom_range(0, 15),
						cursor + 64'($urandom_range(0, 900)), $urandom_range(0, 9) != 0));
				n = $urandom_range(2, 6);
				for (i = 0; i < n; i++) begin
					r = $urandom_range(0, 19);
					if (r == 0) begin
						cursor = cursor + 64'($urandom_range(0, 300));
						queue_cmd(cmd_poll(cursor, 1'b0, 1'($urandom_range(0, 1))));
					end else if (r == 1) begin
						cursor = cursor + 64'($urandom_range(0, 300));
						queue_cmd(cmd_poll(cursor, 1'b1, 1'b1));
					end else if (r == 2) begin
						cursor = cursor - 64'($urandom_range(0, 50));
						queue_cmd(cmd_poll(cursor, 1'b1, 1'b0));
					end else begin
						cursor = cursor + 64'($urandom_range(1, 300));
						queue_cmd(cmd_poll(cursor, 1'b1, 1'b0));
					end
					// Occasional marker between polls, sometimes exactly on the stored position.
					r = $urandom_range(0, 9);
					if (r == 0)
						queue_cmd(cmd_write($urandom_range(0, 15), cursor, 1'b1));
					else if (r < 3)
						queue_cmd(cmd_write($urandom_range(0, 15),
							cursor + 64'($urandom_range(0, 600)), 1'b1));
				end
			end
		end

		// Wait for every command to be taken and every crossing to be reported.
		do
			@(negedge clk);
		while (pending_cmds.size() != 0 || holding || crossings_due.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (crossings_due.size() != 0) begin
			mismatches++;
			$display("%0d predicted crossings were never reported", crossings_due.size());
		end
		$display("Ran %0d commands (writes, set, forget and polls over the full signed range);",
			cmds_taken);
		$display("%0d polls crossed markers, %0d crossing reports checked, %0d mismatches.",
			crossing_polls, reports_checked, mismatches);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/mcd_pkg.sv
hdl/mcd_ram.sv
hdl/mcd_cand.sv
hdl/marker_crossing_detector.sv
bench/tb.sv
